// ===== design/ofip_pkg.sv =====
// Package with constants and types shared by the face index parser files.
package ofip_pkg;

   localparam int INDEX_BITS_DEF = 24;
   localparam int OUT_BITS       = 24;
   localparam int LAYOUT_BITS    = 2;

   localparam logic [LAYOUT_BITS-1:0] LAYOUT_RESET = 2'd3;
   localparam int LAYOUT_TEX_BIT  = 0;
   localparam int LAYOUT_NORM_BIT = 1;

   localparam logic [7:0] CHAR_SLASH   = 8'h2f;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   typedef enum logic [1:0] {
      SLOT_POS  = 2'd0,
      SLOT_TEX  = 2'd1,
      SLOT_NORM = 2'd2
   } slot_type;

   typedef enum logic [1:0] {
      CNT_NONE = 2'd0,
      CNT_ONE  = 2'd1,
      CNT_TWO  = 2'd2
   } count_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] pos;
      logic signed [OUT_BITS-1:0] tex;
      logic signed [OUT_BITS-1:0] norm;
   } corner_type;

   typedef struct packed {
      corner_type first;
      corner_type second;
      corner_type third;
      logic       has_tex;
      logic       has_norm;
   } result_type;

endpackage

// ===== design/ofip_req_if.sv =====
// Input channel carrying one text byte per word.
interface ofip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       new_file;

   modport source (output valid, output text_byte, output new_file, input ready);
   modport sink (input valid, input text_byte, input new_file, output ready);
endinterface

// ===== design/ofip_rsp_if.sv =====
// Result channel carrying one triangle per word.
interface ofip_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ofip_pkg::OUT_BITS-1:0] first_pos;
   logic signed [ofip_pkg::OUT_BITS-1:0] first_tex;
   logic signed [ofip_pkg::OUT_BITS-1:0] first_norm;
   logic signed [ofip_pkg::OUT_BITS-1:0] second_pos;
   logic signed [ofip_pkg::OUT_BITS-1:0] second_tex;
   logic signed [ofip_pkg::OUT_BITS-1:0] second_norm;
   logic signed [ofip_pkg::OUT_BITS-1:0] third_pos;
   logic signed [ofip_pkg::OUT_BITS-1:0] third_tex;
   logic signed [ofip_pkg::OUT_BITS-1:0] third_norm;
   logic                                  has_tex;
   logic                                  has_norm;

   modport source (output valid, output first_pos, output first_tex, output first_norm,
                   output second_pos, output second_tex, output second_norm,
                   output third_pos, output third_tex, output third_norm,
                   output has_tex, output has_norm, input ready);
   modport sink (input valid, input first_pos, input first_tex, input first_norm,
                 input second_pos, input second_tex, input second_norm,
                 input third_pos, input third_tex, input third_norm,
                 input has_tex, input has_norm, output ready);
endinterface

// ===== design/ofip_digit_acc.sv =====
// Saturating decimal accumulate of one digit into a token magnitude.
module ofip_digit_acc #(
   parameter int INDEX_BITS = ofip_pkg::INDEX_BITS_DEF
) (
   input  logic [INDEX_BITS-1:0] accum,
   input  logic                  negative,
   input  logic [3:0]            digit,
   output logic [INDEX_BITS-1:0] accum_next
);

   localparam int WIDE_BITS = INDEX_BITS + 4;

   logic [WIDE_BITS-1:0] accum_wide;
   logic [WIDE_BITS-1:0] product;
   logic [WIDE_BITS-1:0] limit;

   assign accum_wide = WIDE_BITS'(accum);
   assign product    = (accum_wide << 3) + (accum_wide << 1) + WIDE_BITS'(digit);
   assign limit      = (WIDE_BITS'(1) << (INDEX_BITS - 1)) - WIDE_BITS'(!negative);
   assign accum_next = (product > limit) ? limit[INDEX_BITS-1:0]
                                         : product[INDEX_BITS-1:0];

endmodule

// ===== design/obj_face_index_parser_fan.sv =====
// Top level of the face index parser with fan triangulation.
// Each word on req_bus is one character of face index text; the block accepts one word
// per clock cycle whenever its result register is empty or is being emptied in the same
// cycle, so with rsp_bus.ready held high it sustains one character per cycle. A triangle
// is registered and shown on rsp_bus in the cycle after the space or newline that
// completes its third or later corner. Each digit is folded into the current token by
// a combinational multiply-by-ten saturating accumulate, which works directly on the
// parser state registers. Indices saturate at the range of INDEX_BITS and the low 24 bits
// of each index appear on the outputs; has_tex and has_norm are the sticky seen flags
// masked by the layout register written through csr_we and csr_wdata.
module obj_face_index_parser_fan #(
   parameter int INDEX_BITS = ofip_pkg::INDEX_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ofip_pkg::LAYOUT_BITS-1:0] csr_wdata,
   ofip_req_if.sink                         req_bus,
   ofip_rsp_if.source                       rsp_bus
);

   localparam int OB       = ofip_pkg::OUT_BITS;
   localparam int EXT_BITS = (INDEX_BITS > OB) ? INDEX_BITS : OB;

   logic [ofip_pkg::LAYOUT_BITS-1:0] layout_ff;
   logic [INDEX_BITS-1:0]            accum_ff, accum_in;
   logic                             neg_ff, neg_in;
   logic                             stop_ff, stop_in;
   logic                             started_ff, started_in;
   ofip_pkg::slot_type               slot_ff, slot_in;
   logic                             afs_ff, afs_in;
   logic signed [OB-1:0]             vpos_ff, vpos_in;
   logic signed [OB-1:0]             vtex_ff, vtex_in;
   ofip_pkg::corner_type             pin_ff, pin_in;
   ofip_pkg::corner_type             prev_ff, prev_in;
   ofip_pkg::count_type              cnt_ff, cnt_in;
   logic                             tex_seen_ff, tex_seen_in;
   logic                             norm_seen_ff, norm_seen_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ofip_pkg::result_type             rsp_ff, rsp_in;

   logic                             req_fire;
   logic                             emit;
   logic                             clr;
   logic [INDEX_BITS-1:0]            cur_accum, acc_next;
   logic                             cur_neg, cur_stop, cur_started, cur_afs;
   ofip_pkg::slot_type               cur_slot;
   logic signed [OB-1:0]             cur_vpos, cur_vtex;
   ofip_pkg::corner_type             cur_pin, cur_prev;
   ofip_pkg::count_type              cur_cnt;
   logic                             cur_tex_seen, cur_norm_seen;
   logic signed [INDEX_BITS-1:0]     tok_s;
   logic signed [EXT_BITS-1:0]       tok_w;
   logic signed [OB-1:0]             tok;
   logic [7:0]                       ch;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign ch            = req_bus.text_byte;
   assign clr           = req_bus.new_file;

   assign cur_accum     = clr ? '0 : accum_ff;
   assign cur_neg       = clr ? 1'b0 : neg_ff;
   assign cur_stop      = clr ? 1'b0 : stop_ff;
   assign cur_started   = clr ? 1'b0 : started_ff;
   assign cur_afs       = clr ? 1'b0 : afs_ff;
   assign cur_slot      = clr ? ofip_pkg::SLOT_POS : slot_ff;
   assign cur_vpos      = clr ? '0 : vpos_ff;
   assign cur_vtex      = clr ? '0 : vtex_ff;
   assign cur_pin       = clr ? '0 : pin_ff;
   assign cur_prev      = clr ? '0 : prev_ff;
   assign cur_cnt       = clr ? ofip_pkg::CNT_NONE : cnt_ff;
   assign cur_tex_seen  = clr ? 1'b0 : tex_seen_ff;
   assign cur_norm_seen = clr ? 1'b0 : norm_seen_ff;

   ofip_digit_acc #(
      .INDEX_BITS(INDEX_BITS)
   ) u_digit_acc (
      .accum      (cur_accum),
      .negative   (cur_neg),
      .digit      (4'(ch - ofip_pkg::CHAR_ZERO)),
      .accum_next (acc_next)
   );

   // The negated magnitude of a negative token is exactly representable in INDEX_BITS.
   assign tok_s = cur_neg ? -$signed(cur_accum) : $signed(cur_accum);
   assign tok_w = EXT_BITS'(tok_s);
   assign tok   = tok_w[OB-1:0];

   always_comb begin
      ofip_pkg::corner_type vtx;
      vtx          = '0;
      accum_in     = accum_ff;
      neg_in       = neg_ff;
      stop_in      = stop_ff;
      started_in   = started_ff;
      slot_in      = slot_ff;
      afs_in       = afs_ff;
      vpos_in      = vpos_ff;
      vtex_in      = vtex_ff;
      pin_in       = pin_ff;
      prev_in      = prev_ff;
      cnt_in       = cnt_ff;
      tex_seen_in  = tex_seen_ff;
      norm_seen_in = norm_seen_ff;
      emit         = 1'b0;
      rsp_in       = rsp_ff;
      if (req_fire) begin
         accum_in     = cur_accum;
         neg_in       = cur_neg;
         stop_in      = cur_stop;
         started_in   = cur_started;
         slot_in      = cur_slot;
         afs_in       = 1'b0;
         vpos_in      = cur_vpos;
         vtex_in      = cur_vtex;
         pin_in       = cur_pin;
         prev_in      = cur_prev;
         cnt_in       = cur_cnt;
         tex_seen_in  = cur_tex_seen || (cur_afs && (ch != ofip_pkg::CHAR_SLASH));
         norm_seen_in = cur_norm_seen;
         if (ch >= ofip_pkg::CHAR_ZERO && ch <= ofip_pkg::CHAR_NINE) begin
            if (!cur_stop) begin
               accum_in = acc_next;
            end
            started_in = 1'b1;
         end else if (ch == ofip_pkg::CHAR_MINUS) begin
            if (!cur_started) begin
               neg_in = 1'b1;
            end else begin
               stop_in = 1'b1;
            end
            started_in = 1'b1;
         end else if (ch == ofip_pkg::CHAR_SLASH) begin
            if (cur_slot == ofip_pkg::SLOT_POS) begin
               vpos_in    = tok;
               afs_in     = 1'b1;
               slot_in    = ofip_pkg::SLOT_TEX;
               accum_in   = '0;
               neg_in     = 1'b0;
               stop_in    = 1'b0;
               started_in = 1'b0;
            end else if (cur_slot == ofip_pkg::SLOT_TEX) begin
               vtex_in      = tok;
               norm_seen_in = 1'b1;
               slot_in      = ofip_pkg::SLOT_NORM;
               accum_in     = '0;
               neg_in       = 1'b0;
               stop_in      = 1'b0;
               started_in   = 1'b0;
            end
         end else if (ch == ofip_pkg::CHAR_SPACE || ch == ofip_pkg::CHAR_NEWLINE) begin
            if (cur_started || cur_slot != ofip_pkg::SLOT_POS) begin
               vtx.pos = cur_vpos;
               vtx.tex = cur_vtex;
               case (cur_slot)
                  ofip_pkg::SLOT_POS: vtx.pos  = tok;
                  ofip_pkg::SLOT_TEX: vtx.tex  = tok;
                  default:            vtx.norm = tok;
               endcase
               accum_in   = '0;
               neg_in     = 1'b0;
               stop_in    = 1'b0;
               started_in = 1'b0;
               vpos_in    = '0;
               vtex_in    = '0;
               slot_in    = ofip_pkg::SLOT_POS;
               if (cur_cnt == ofip_pkg::CNT_NONE) begin
                  pin_in = vtx;
                  cnt_in = ofip_pkg::CNT_ONE;
               end else begin
                  if (cur_cnt == ofip_pkg::CNT_TWO) begin
                     emit            = 1'b1;
                     rsp_in.first    = cur_pin;
                     rsp_in.second   = cur_prev;
                     rsp_in.third    = vtx;
                     rsp_in.has_tex  = tex_seen_in &&
                                       layout_ff[ofip_pkg::LAYOUT_TEX_BIT];
                     rsp_in.has_norm = cur_norm_seen &&
                                       layout_ff[ofip_pkg::LAYOUT_NORM_BIT];
                  end
                  prev_in = vtx;
                  cnt_in  = ofip_pkg::CNT_TWO;
               end
            end
            if (ch == ofip_pkg::CHAR_NEWLINE) begin
               accum_in   = '0;
               neg_in     = 1'b0;
               stop_in    = 1'b0;
               started_in = 1'b0;
               vpos_in    = '0;
               vtex_in    = '0;
               slot_in    = ofip_pkg::SLOT_POS;
               cnt_in     = ofip_pkg::CNT_NONE;
            end
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff    <= ofip_pkg::LAYOUT_RESET;
         accum_ff     <= '0;
         neg_ff       <= 1'b0;
         stop_ff      <= 1'b0;
         started_ff   <= 1'b0;
         slot_ff      <= ofip_pkg::SLOT_POS;
         afs_ff       <= 1'b0;
         vpos_ff      <= '0;
         vtex_ff      <= '0;
         pin_ff       <= '0;
         prev_ff      <= '0;
         cnt_ff       <= ofip_pkg::CNT_NONE;
         tex_seen_ff  <= 1'b0;
         norm_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            layout_ff <= csr_wdata;
         end
         accum_ff     <= accum_in;
         neg_ff       <= neg_in;
         stop_ff      <= stop_in;
         started_ff   <= started_in;
         slot_ff      <= slot_in;
         afs_ff       <= afs_in;
         vpos_ff      <= vpos_in;
         vtex_ff      <= vtex_in;
         pin_ff       <= pin_in;
         prev_ff      <= prev_in;
         cnt_ff       <= cnt_in;
         tex_seen_ff  <= tex_seen_in;
         norm_seen_ff <= norm_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.first_pos   = rsp_ff.first.pos;
   assign rsp_bus.first_tex   = rsp_ff.first.tex;
   assign rsp_bus.first_norm  = rsp_ff.first.norm;
   assign rsp_bus.second_pos  = rsp_ff.second.pos;
   assign rsp_bus.second_tex  = rsp_ff.second.tex;
   assign rsp_bus.second_norm = rsp_ff.second.norm;
   assign rsp_bus.third_pos   = rsp_ff.third.pos;
   assign rsp_bus.third_tex   = rsp_ff.third.tex;
   assign rsp_bus.third_norm  = rsp_ff.third.norm;
   assign rsp_bus.has_tex     = rsp_ff.has_tex;
   assign rsp_bus.has_norm    = rsp_ff.has_norm;

   // A new triangle only appears after an accepted word.
   a_rsp_from_word : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire))
      else $error("result appeared without an accepted word");

   // A newline always closes the polygon.
   a_newline_closes : assert property (@(posedge clock) disable iff (reset)
      req_fire && ch == ofip_pkg::CHAR_NEWLINE |=> cnt_ff == ofip_pkg::CNT_NONE)
      else $error("corner count not cleared after newline");

   // The texture check is pending only right after the first slash of a vertex.
   a_afs_slot : assert property (@(posedge clock) disable iff (reset)
      afs_ff |-> slot_ff == ofip_pkg::SLOT_TEX)
      else $error("first slash flag set outside the texture slot");

endmodule
